/* hw/rtl/telnet_receive_negotiator_macros.svh */
// Assertion macros shared by the telnet receive negotiator RTL.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef TELNET_RECEIVE_NEGOTIATOR_MACROS_SVH
`define TELNET_RECEIVE_NEGOTIATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define TNRN_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tnrn: assertion failed");

// Next-cycle implication, disabled while reset is low.
`define TNRN_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tnrn: assertion failed");

`endif

/* hw/rtl/tnrn_pkg.sv */
// Package for the telnet receive negotiator: protocol codes, action record,
// queue status and the opening-offer table. No dependencies.
package tnrn_pkg;

    localparam logic [7:0] TN_IAC  = 8'd255;
    localparam logic [7:0] TN_DONT = 8'd254;
    localparam logic [7:0] TN_DO   = 8'd253;
    localparam logic [7:0] TN_WONT = 8'd252;
    localparam logic [7:0] TN_WILL = 8'd251;
    localparam logic [7:0] TN_SB   = 8'd250;
    localparam logic [7:0] TN_SE   = 8'd240;

    localparam logic [7:0] OPT_BINARY  = 8'd0;
    localparam logic [7:0] OPT_ECHO    = 8'd1;
    localparam logic [7:0] OPT_SGA     = 8'd3;
    localparam logic [7:0] OPT_COMPORT = 8'd44;

    localparam logic [7:0] CH_ESC = 8'd27;
    localparam logic [7:0] CH_SQR = 8'd91;

    // printable window: DATA_LO <= byte < DATA_HI
    localparam logic [7:0] DATA_LO = 8'd3;
    localparam logic [7:0] DATA_HI = 8'd127;

    // option bits after a new connection: local SGA/ECHO/BINARY, remote SGA/BINARY
    localparam logic [31:0] OFFER_LOCAL  = 32'h0000_000B;
    localparam logic [31:0] OFFER_REMOTE = 32'h0000_0009;

    localparam int REPLY_LEN = 3;
    localparam int OFFER_LEN = 15;

    localparam int TNRN_QUEUE_AW = 2;

    typedef enum logic [1:0] {
        ACT_DATA  = 2'd0,
        ACT_REPLY = 2'd1,
        ACT_OFFER = 2'd2
    } t_act_kind;

    typedef struct packed {
        t_act_kind  kind;
        logic [7:0] verb;
        logic [7:0] val;
    } t_action;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [7:0] offer_byte(input logic [3:0] idx);
        logic [7:0] b;
        b = TN_IAC;
        unique case (idx)
            4'd1:    b = TN_WILL;
            4'd2:    b = OPT_SGA;
            4'd4:    b = TN_DO;
            4'd5:    b = OPT_SGA;
            4'd7:    b = TN_WILL;
            4'd8:    b = OPT_ECHO;
            4'd10:   b = TN_WILL;
            4'd11:   b = OPT_BINARY;
            4'd13:   b = TN_DO;
            4'd14:   b = OPT_BINARY;
            default: b = TN_IAC;
        endcase
        return b;
    endfunction

endpackage

/* hw/rtl/tnrn_ifs.sv */
// Valid/ready channel interfaces of the telnet receive negotiator.
// Depends on nothing.
interface tnrn_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] rx_byte;

    modport source (output valid, cmd, rx_byte, input ready);
    modport sink   (input valid, cmd, rx_byte, output ready);
endinterface

interface tnrn_out_if;
    logic       valid;
    logic       ready;
    logic       dest;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, dest, out_byte, last, input ready);
    modport sink   (input valid, dest, out_byte, last, output ready);
endinterface

/* hw/rtl/tnrn_front.sv */
// Front end: accepts network bytes, runs the telnet parser and option bits,
// and pushes one action per producing byte. Uses tnrn_pkg, tnrn_in_if.
module tnrn_front
    import tnrn_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    tnrn_in_if.sink       i_in,
    input  t_q_status     i_q_status,
    output logic          o_push,
    output t_action       o_act
);

    typedef enum logic [12:0] {
        PS_DATA       = 13'h0001,
        PS_IAC        = 13'h0002,
        PS_DONT       = 13'h0004,
        PS_DO         = 13'h0008,
        PS_WONT       = 13'h0010,
        PS_WILL       = 13'h0020,
        PS_SB_ID      = 13'h0040,
        PS_SB         = 13'h0080,
        PS_SB_IAC     = 13'h0100,
        PS_ESC        = 13'h0200,
        PS_ESC_SQR    = 13'h0400,
        PS_BAD_SB     = 13'h0800,
        PS_BAD_SB_IAC = 13'h1000
    } t_parse_state;

    t_parse_state r_state, n_state;
    logic [31:0]  r_local, n_local;
    logic [31:0]  r_remote, n_remote;
    logic         r_binary, n_binary;

    logic         accept;
    logic [7:0]   c;
    logic         neg_valid, neg_local, neg_set;
    logic [31:0]  neg_bits;
    logic         push;
    t_action      act;

    assign i_in.ready = i_rst_n && !i_q_status.full;
    assign accept     = i_in.valid && i_in.ready;
    assign c          = i_in.rx_byte;

    always_comb begin
        n_state   = r_state;
        n_local   = r_local;
        n_remote  = r_remote;
        n_binary  = r_binary;
        neg_valid = 1'b0;
        neg_local = 1'b0;
        neg_set   = 1'b0;
        neg_bits  = r_remote;
        push      = 1'b0;
        act       = '{kind: ACT_DATA, verb: 8'd0, val: c};
        if (i_in.cmd) begin
            n_state  = PS_DATA;
            n_local  = OFFER_LOCAL;
            n_remote = OFFER_REMOTE;
            n_binary = 1'b0;
            push     = 1'b1;
            act.kind = ACT_OFFER;
        end else begin
            unique case (r_state)
                PS_DATA: begin
                    if (c == TN_IAC) begin
                        n_state = PS_IAC;
                    end else if (r_binary || (c >= DATA_LO && c < DATA_HI)) begin
                        push = 1'b1;
                    end else if (c == CH_ESC) begin
                        n_state = PS_ESC;
                    end
                end
                PS_IAC: begin
                    priority if (c == TN_DONT) n_state = PS_DONT;
                    else if (c == TN_DO)       n_state = PS_DO;
                    else if (c == TN_WONT)     n_state = PS_WONT;
                    else if (c == TN_WILL)     n_state = PS_WILL;
                    else if (c == TN_SB)       n_state = PS_SB_ID;
                    else                       n_state = PS_DATA;
                end
                PS_DONT: begin
                    neg_valid = 1'b1;
                    neg_local = 1'b1;
                    n_state   = PS_DATA;
                end
                PS_DO: begin
                    neg_valid = 1'b1;
                    neg_local = 1'b1;
                    neg_set   = (c == OPT_SGA) || (c == OPT_ECHO) || (c == OPT_BINARY);
                    n_state   = PS_DATA;
                end
                PS_WONT: begin
                    neg_valid = 1'b1;
                    n_state   = PS_DATA;
                end
                PS_WILL: begin
                    neg_valid = 1'b1;
                    neg_set   = (c == OPT_SGA) || (c == OPT_BINARY);
                    if (c == OPT_BINARY) begin
                        n_binary = 1'b1;
                    end
                    n_state = PS_DATA;
                end
                PS_SB_ID:      n_state = (c == OPT_COMPORT) ? PS_SB : PS_BAD_SB;
                PS_SB:         if (c == TN_IAC) n_state = PS_SB_IAC;
                PS_SB_IAC:     n_state = (c == TN_SE) ? PS_DATA : PS_SB;
                PS_BAD_SB:     if (c == TN_IAC) n_state = PS_BAD_SB_IAC;
                PS_BAD_SB_IAC: n_state = (c == TN_SE) ? PS_DATA : PS_BAD_SB;
                PS_ESC:        n_state = (c == CH_SQR) ? PS_ESC_SQR : PS_DATA;
                default:       n_state = PS_DATA;
            endcase

            // option verbs: reply only when the bit actually flips, options 0..31
            neg_bits = neg_local ? r_local : r_remote;
            if (neg_valid && c[7:5] == 3'd0 && neg_bits[c[4:0]] != neg_set) begin
                push     = 1'b1;
                act.kind = ACT_REPLY;
                if (neg_local) begin
                    n_local[c[4:0]] = neg_set;
                    act.verb        = neg_set ? TN_WILL : TN_WONT;
                end else begin
                    n_remote[c[4:0]] = neg_set;
                    act.verb         = neg_set ? TN_DO : TN_DONT;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= PS_DATA;
            r_local  <= '0;
            r_remote <= '0;
            r_binary <= 1'b0;
        end else if (accept) begin
            r_state  <= n_state;
            r_local  <= n_local;
            r_remote <= n_remote;
            r_binary <= n_binary;
        end
    end

    assign o_push = accept && push;
    assign o_act  = act;

endmodule

/* hw/rtl/tnrn_queue.sv */
// Small action queue between parser and emitter, register file with
// combinational head read. Uses tnrn_pkg and the assertion macros.
`include "telnet_receive_negotiator_macros.svh"

module tnrn_queue
    import tnrn_pkg::*;
#(
    parameter int Q_AW = TNRN_QUEUE_AW
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_action   i_act,
    input  logic      i_pop,
    output t_action   o_head,
    output t_q_status o_status
);

    localparam int DEPTH = 1 << Q_AW;

    t_action          r_slot [DEPTH];
    logic [Q_AW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [Q_AW:0]    r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= r_count + (Q_AW+1)'(i_push) - (Q_AW+1)'(i_pop);
        end
    end

    assign o_head         = r_slot[r_rd_ptr];
    assign o_status.full  = (r_count == (Q_AW+1)'(DEPTH));
    assign o_status.empty = (r_count == '0);

    `TNRN_ASSERT_NOW(a_no_overflow, i_push, r_count < (Q_AW+1)'(DEPTH))
    `TNRN_ASSERT_NOW(a_no_underflow, i_pop, r_count != '0)
    `TNRN_ASSERT_NXT(a_count_track, 1'b1, r_count == $past(r_count) + (Q_AW+1)'($past(i_push)) - (Q_AW+1)'($past(i_pop)))

endmodule

/* hw/rtl/tnrn_back.sv */
// Back end: expands the head action into the output register, one byte per
// cycle while not stalled. Uses tnrn_pkg, tnrn_out_if and the assertion macros.
`include "telnet_receive_negotiator_macros.svh"

module tnrn_back
    import tnrn_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_action    i_head,
    input  t_q_status  i_q_status,
    output logic       o_pop,
    tnrn_out_if.source o_out
);

    logic [3:0] r_idx, n_idx;
    logic       r_valid;
    logic       r_dest;
    logic [7:0] r_byte;
    logic       r_last;

    logic       load_ok, take;
    logic [7:0] cur_byte;
    logic       cur_last;

    assign load_ok = !r_valid || o_out.ready;
    assign take    = load_ok && !i_q_status.empty;

    always_comb begin
        cur_byte = i_head.val;
        cur_last = 1'b1;
        unique case (i_head.kind)
            ACT_DATA: begin
                cur_byte = i_head.val;
                cur_last = 1'b1;
            end
            ACT_REPLY: begin
                cur_byte = (r_idx == 4'd0) ? TN_IAC :
                           (r_idx == 4'd1) ? i_head.verb : i_head.val;
                cur_last = (r_idx == 4'(REPLY_LEN - 1));
            end
            ACT_OFFER: begin
                cur_byte = offer_byte(r_idx);
                cur_last = (r_idx == 4'(OFFER_LEN - 1));
            end
            default: begin
                cur_byte = i_head.val;
                cur_last = 1'b1;
            end
        endcase
    end

    assign o_pop = take && cur_last;
    assign n_idx = !take ? r_idx : (cur_last ? 4'd0 : r_idx + 4'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (load_ok) r_valid <= take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_dest <= (i_head.kind != ACT_DATA);
            r_byte <= cur_byte;
            r_last <= cur_last;
        end
    end

    assign o_out.valid    = r_valid;
    assign o_out.dest     = r_dest;
    assign o_out.out_byte = r_byte;
    assign o_out.last     = r_last;

    `TNRN_ASSERT_NOW(a_pop_on_last, o_pop, cur_last && take)
    `TNRN_ASSERT_NOW(a_mid_action_head, r_idx != 4'd0, !i_q_status.empty && i_head.kind != ACT_DATA)
    `TNRN_ASSERT_NOW(a_idx_range, 1'b1, r_idx < 4'(OFFER_LEN))

endmodule

/* hw/rtl/telnet_receive_negotiator.sv */
// Top level of the telnet receive negotiator: parser front end, action
// queue, byte emitter. Uses tnrn_pkg, tnrn_ifs, tnrn_front/queue/back.
//
//   channel  dir  payload                    transfer when
//   i_in     in   cmd, rx_byte               valid && ready
//   o_out    out  dest, out_byte, last       valid && ready
//
// Flow: the front takes one byte per cycle while the queue has room; the
//   emitter sends one result byte per cycle while the output accepts it; a data
//   byte yields 1 result byte, a reply 3 and a new connection 15.
// The 2^Q_AW-entry action queue absorbs replies; input stalls only when it
//   fills behind a stalled or busy output.
// Reset: synchronous, active low; clears parser state, option bits, binary
//   mode, queue pointers and output valid. ready is low while in reset.
module telnet_receive_negotiator
    import tnrn_pkg::*;
#(
    parameter int Q_AW = TNRN_QUEUE_AW
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tnrn_in_if.sink    i_in,
    tnrn_out_if.source o_out
);

    // front -> queue
    logic      push;
    t_action   push_act;
    // queue -> back
    t_action   head;
    logic      pop;
    t_q_status q_status;

    // parser, option bits and action classification
    tnrn_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_q_status (q_status),
        .o_push     (push),
        .o_act      (push_act)
    );

    // decouples parsing from byte emission
    tnrn_queue #(
        .Q_AW (Q_AW)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_act    (push_act),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    // expands each action into result bytes behind an output register
    tnrn_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_out      (o_out)
    );

endmodule

/* tb/tb_telnet_receive_negotiator.sv */
`timescale 1ns / 1ps
// Self-checking testbench for telnet_receive_negotiator: drives network bytes
// and new-connection items, predicts serial data and negotiation replies.
// Depends on tnrn_pkg, tnrn_ifs and the negotiator RTL.
module tb_telnet_receive_negotiator;
    import tnrn_pkg::*;

    // IAC commands and options that the package does not name
    localparam logic [7:0] TN_NOP         = 8'd241;
    localparam logic [7:0] TN_CMD_FIRST   = 8'd240;
    localparam logic [7:0] TN_CMD_LAST    = 8'd249;
    localparam logic [7:0] OPT_MAP_TOP    = 8'd31;
    localparam logic [7:0] OPT_OUT_OF_MAP = 8'd40;

    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 90;
    localparam int DRAIN_CYCLES  = 20;

    typedef enum logic [3:0] {
        PS_DATA,
        PS_IAC,
        PS_DONT,
        PS_DO,
        PS_WONT,
        PS_WILL,
        PS_SB_ID,
        PS_SUB,
        PS_SUB_IAC,
        PS_ESC,
        PS_ESC_SQR
    } t_parse_st;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } t_net_item;

    typedef struct packed {
        logic       dest;
        logic [7:0] out_byte;
        logic       last;
    } t_tx_byte;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    tnrn_in_if  in_ch ();
    tnrn_out_if out_ch ();

    telnet_receive_negotiator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: parser, option maps, binary flag
    // ------------------------------------------------------------------
    t_parse_st   parse_st    = PS_DATA;
    logic [31:0] local_bits  = '0;
    logic [31:0] remote_bits = '0;
    logic        binary_on   = 1'b0;

    t_tx_byte  staged[$];       // results of the transfer being predicted
    t_tx_byte  owed[$];         // results still due from the block
    t_net_item net_items[$];    // items waiting for the driver

    int   items_queued   = 0;
    int   mismatches     = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_go        = 1'b0;
    int   hold_cycles    = 0;
    logic in_taken       = 1'b0;

    task automatic stage(input logic dest, input logic [7:0] b);
        t_tx_byte x;
        x.dest     = dest;
        x.out_byte = b;
        x.last     = 1'b0;
        staged.push_back(x);
    endtask

    // Move an option bit toward turn_on; a reply goes out only on a change.
    task automatic settle_option(input bit is_local, input bit turn_on,
                                 input logic [7:0] opt);
        logic [31:0] mask;
        logic [31:0] bits;
        logic [7:0]  verb;
        if (opt > OPT_MAP_TOP) return;
        mask = 32'd1 << opt[4:0];
        bits = is_local ? local_bits : remote_bits;
        if (turn_on == ((bits & mask) != 0)) return;
        bits = turn_on ? (bits | mask) : (bits & ~mask);
        if (is_local) begin
            local_bits = bits;
            verb = turn_on ? TN_WILL : TN_WONT;
        end else begin
            remote_bits = bits;
            verb = turn_on ? TN_DO : TN_DONT;
        end
        stage(1'b1, TN_IAC);
        stage(1'b1, verb);
        stage(1'b1, opt);
    endtask

    task automatic parse_transfer(input logic cmd, input logic [7:0] c);
        t_tx_byte x;
        staged.delete();
        if (cmd) begin
            // new connection: wipe everything, then the opening offers
            parse_st    = PS_DATA;
            local_bits  = '0;
            remote_bits = '0;
            binary_on   = 1'b0;
            settle_option(1'b1, 1'b1, OPT_SGA);
            settle_option(1'b0, 1'b1, OPT_SGA);
            settle_option(1'b1, 1'b1, OPT_ECHO);
            settle_option(1'b1, 1'b1, OPT_BINARY);
            settle_option(1'b0, 1'b1, OPT_BINARY);
        end else begin
            case (parse_st)
                PS_DATA: begin
                    if (c == TN_IAC)
                        parse_st = PS_IAC;
                    else if (binary_on || (c >= DATA_LO && c < DATA_HI))
                        stage(1'b0, c);
                    else if (c == CH_ESC)
                        parse_st = PS_ESC;
                end
                PS_IAC: begin
                    case (c)
                        TN_DONT: parse_st = PS_DONT;
                        TN_DO:   parse_st = PS_DO;
                        TN_WONT: parse_st = PS_WONT;
                        TN_WILL: parse_st = PS_WILL;
                        TN_SB:   parse_st = PS_SB_ID;
                        default: parse_st = PS_DATA;
                    endcase
                end
                PS_DONT: begin
                    settle_option(1'b1, 1'b0, c);
                    parse_st = PS_DATA;
                end
                PS_DO: begin
                    settle_option(1'b1, c == OPT_SGA || c == OPT_ECHO || c == OPT_BINARY, c);
                    parse_st = PS_DATA;
                end
                PS_WONT: begin
                    settle_option(1'b0, 1'b0, c);
                    parse_st = PS_DATA;
                end
                PS_WILL: begin
                    settle_option(1'b0, c == OPT_SGA || c == OPT_BINARY, c);
                    if (c == OPT_BINARY) binary_on = 1'b1;
                    parse_st = PS_DATA;
                end
                // com-port and unknown subnegotiations are skipped the same way
                PS_SB_ID:   parse_st = PS_SUB;
                PS_SUB:     if (c == TN_IAC) parse_st = PS_SUB_IAC;
                PS_SUB_IAC: parse_st = (c == TN_SE) ? PS_DATA : PS_SUB;
                PS_ESC:     parse_st = (c == CH_SQR) ? PS_ESC_SQR : PS_DATA;
                default:    parse_st = PS_DATA;
            endcase
        end
        for (int i = 0; i < staged.size(); i++) begin
            x      = staged[i];
            x.last = (i == staged.size() - 1);
            owed.push_back(x);
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: predict on input transfers, check output transfers
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_tx_byte want;
        in_taken <= in_ch.valid && in_ch.ready;
        if (in_ch.valid && in_ch.ready)
            parse_transfer(in_ch.cmd, in_ch.rx_byte);
        if (out_ch.valid && out_ch.ready) begin
            if (owed.size() == 0) begin
                $error("unexpected transfer: dest %0d out_byte %02h last %0d",
                       out_ch.dest, out_ch.out_byte, out_ch.last);
                mismatches++;
            end else begin
                want = owed.pop_front();
                if (out_ch.dest !== want.dest) begin
                    $error("dest: expected %0d, got %0d", want.dest, out_ch.dest);
                    mismatches++;
                end
                if (out_ch.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %02h, got %02h",
                           want.out_byte, out_ch.out_byte);
                    mismatches++;
                end
                if (out_ch.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, out_ch.last);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: holds an offered item until it is taken
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_net_item nxt;
        if (!(in_ch.valid && !in_taken)) begin
            if (i_rst_n && net_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = net_items.pop_front();
                in_ch.valid   <= 1'b1;
                in_ch.cmd     <= nxt.cmd;
                in_ch.rx_byte <= nxt.rx_byte;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver side: random stalls, plus a forced hold-off when hold_go is up
    always @(negedge i_clk)
        out_ch.ready <= !hold_go && ($urandom_range(99) >= recv_stall_pct);

    always @(negedge i_clk)
        if (hold_go) hold_cycles <= hold_cycles + 1;

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic queue_item(input logic cmd, input logic [7:0] b);
        t_net_item it;
        it.cmd     = cmd;
        it.rx_byte = b;
        net_items.push_back(it);
        items_queued++;
    endtask

    function automatic logic [7:0] pick_verb();
        logic [7:0] v;
        case ($urandom_range(3))
            0:       v = TN_DO;
            1:       v = TN_DONT;
            2:       v = TN_WILL;
            default: v = TN_WONT;
        endcase
        return v;
    endfunction

    // Option bytes lean toward the ones the block answers positively.
    function automatic logic [7:0] pick_option();
        logic [7:0] o;
        case ($urandom_range(4))
            0:       o = OPT_BINARY;
            1:       o = OPT_ECHO;
            2:       o = OPT_SGA;
            3:       o = 8'($urandom_range(31));
            default: o = 8'($urandom_range(255));
        endcase
        return o;
    endfunction

    // One random sequence; mostly well-formed, some noise.
    task automatic queue_sequence();
        int         pick;
        int         body;
        logic [7:0] b;
        pick = $urandom_range(99);
        if (pick < 35) begin
            queue_item(1'b0, 8'($urandom_range(254)));
        end else if (pick < 70) begin
            queue_item(1'b0, TN_IAC);
            queue_item(1'b0, pick_verb());
            queue_item(1'b0, pick_option());
        end else if (pick < 80) begin
            queue_item(1'b0, TN_IAC);
            queue_item(1'b0, TN_SB);
            queue_item(1'b0, $urandom_range(1) ? OPT_COMPORT : 8'($urandom_range(255)));
            body = $urandom_range(4);
            for (int i = 0; i < body; i++) begin
                if ($urandom_range(3) == 0) begin
                    // escaped byte inside the subnegotiation, not SE
                    queue_item(1'b0, TN_IAC);
                    b = 8'($urandom_range(255));
                    if (b == TN_SE) b = TN_IAC;
                    queue_item(1'b0, b);
                end else begin
                    queue_item(1'b0, 8'($urandom_range(254)));
                end
            end
            queue_item(1'b0, TN_IAC);
            queue_item(1'b0, TN_SE);
        end else if (pick < 86) begin
            queue_item(1'b0, TN_IAC);
            queue_item(1'b0, $urandom_range(1) ?
                       8'($urandom_range(TN_CMD_LAST, TN_CMD_FIRST)) : 8'($urandom_range(255)));
        end else if (pick < 90) begin
            queue_item(1'b0, TN_IAC);
            queue_item(1'b0, TN_IAC);
        end else if (pick < 93) begin
            queue_item(1'b1, 8'($urandom_range(255)));
        end else begin
            queue_item(1'b0, 8'($urandom_range(255)));
        end
    endtask

    // Sender pause: nothing offered, nothing owed.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (net_items.size() != 0 || in_ch.valid || owed.size() != 0);
    endtask

    initial begin
        int idle_plan[4];
        int stall_plan[4];
        idle_plan  = '{0, 61, 0, 7};
        stall_plan = '{0, 0, 61, 7};

        in_ch.valid   = 1'b0;
        in_ch.cmd     = 1'b0;
        in_ch.rx_byte = '0;
        out_ch.ready  = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: data window edges, IAC IAC, NOP, each verb, high option,
        // binary mode, then a new connection
        queue_item(1'b0, 8'h00);
        queue_item(1'b0, DATA_LO);
        queue_item(1'b0, DATA_HI - 8'd1);
        queue_item(1'b0, DATA_HI);
        queue_item(1'b0, 8'hFE);
        queue_item(1'b0, TN_IAC);
        queue_item(1'b0, TN_IAC);
        queue_item(1'b0, TN_IAC);
        queue_item(1'b0, TN_NOP);
        queue_item(1'b0, TN_IAC);
        queue_item(1'b0, TN_DO);
        queue_item(1'b0, OPT_ECHO);
        queue_item(1'b0, TN_IAC);
        queue_item(1'b0, TN_DONT);
        queue_item(1'b0, OPT_ECHO);
        queue_item(1'b0, TN_IAC);
        queue_item(1'b0, TN_WILL);
        queue_item(1'b0, OPT_OUT_OF_MAP);
        queue_item(1'b0, TN_IAC);
        queue_item(1'b0, TN_WILL);
        queue_item(1'b0, OPT_BINARY);
        queue_item(1'b0, 8'h00);
        queue_item(1'b0, TN_IAC);
        queue_item(1'b0, TN_WONT);
        queue_item(1'b0, OPT_BINARY);
        queue_item(1'b1, 8'hFF);
        wait_drained();

        // back-pressure: receiver holds off while the sender keeps offering
        @(posedge i_clk);
        hold_go = 1'b1;
        for (int i = 0; i < 20; i++) begin
            queue_item(1'b0, 8'($urandom_range(126, 3)));
            queue_sequence();
        end
        while (hold_cycles < HOLD_CYCLES) @(posedge i_clk);
        hold_go = 1'b0;
        wait_drained();

        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = idle_plan[p];
            recv_stall_pct = stall_plan[p];
            items_queued   = 0;
            while (items_queued < PHASE_ITEMS) queue_sequence();
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/tnrn_pkg.sv
hw/rtl/tnrn_ifs.sv
hw/rtl/tnrn_front.sv
hw/rtl/tnrn_queue.sv
hw/rtl/tnrn_back.sv
hw/rtl/telnet_receive_negotiator.sv
tb/tb_telnet_receive_negotiator.sv
